// File: src/cses_pkg.sv
// ----------------------------------------------------------------------------
// cses_pkg: shared types and constants of the CAN signal extract/scale unit
// Config register layout, register indexes, queue item formats and depths.
// ----------------------------------------------------------------------------
package cses_pkg;

  // field widths
  localparam int IdW      = 29;
  localparam int StdIdW   = 11;
  localparam int WordW    = 64;
  localparam int StartW   = 6;
  localparam int LenW     = 7;
  localparam int ScaleW   = 32;
  localparam int OffsetW  = 48;
  localparam int CfgDataW = 48;
  localparam int CfgIdxW  = 3;

  // wide intermediate sum of raw*scale+offset
  localparam int SumW = 98;

  // queue depths
  localparam int MidDepth = 2;
  localparam int OutDepth = 8;
  localparam int OutCntW  = $clog2(OutDepth + 1);

  // config register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MATCH_ID   = 3'd0,
    REG_FIRST_BIT  = 3'd1,
    REG_BIT_LENGTH = 3'd2,
    REG_BYTE_ORDER = 3'd3,
    REG_IS_SIGNED  = 3'd4,
    REG_SCALE      = 3'd5,
    REG_OFFSET     = 3'd6
  } cses_reg_e;

  // bit order codes
  localparam logic ORDER_MOTOROLA = 1'b0;
  localparam logic ORDER_INTEL    = 1'b1;

  // reset values
  localparam logic [IdW-1:0]     RstMatchId   = '0;
  localparam logic [StartW-1:0]  RstFirstBit  = '0;
  localparam logic [LenW-1:0]    RstBitLength = 7'd8;
  localparam logic               RstByteOrder = ORDER_INTEL;
  localparam logic               RstIsSigned  = 1'b0;
  localparam logic [ScaleW-1:0]  RstScale     = 32'd65536;
  localparam logic [OffsetW-1:0] RstOffset    = '0;

  typedef struct packed {
    logic [IdW-1:0]     match_id;
    logic [StartW-1:0]  first_bit;
    logic [LenW-1:0]    bit_length;
    logic               byte_order;
    logic               is_signed;
    logic [ScaleW-1:0]  scale;
    logic [OffsetW-1:0] offset;
  } cses_cfg_t;

  // classified frame handed from front to back
  typedef struct packed {
    logic             matched;
    logic             sign_ext;
    logic [WordW-1:0] raw;
  } cses_mid_t;

  // finished result
  typedef struct packed {
    logic             matched;
    logic [WordW-1:0] raw;
    logic [WordW-1:0] phys;
    logic             sat;
  } cses_res_t;

  // back-end handshake with the two queues
  typedef struct packed {
    logic               mid_empty;
    logic [OutCntW-1:0] out_count;
  } cses_back_stat_t;

endpackage

// File: src/cses_fifo.sv
// ----------------------------------------------------------------------------
// cses_fifo: small synchronous queue
// Register-array queue with first-word fall-through read and a fill count.
// ----------------------------------------------------------------------------
module cses_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [WIDTH-1:0]           wr_data_i,
  input  logic                       rd_en_i,
  output logic [WIDTH-1:0]           rd_data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign do_wr = wr_en_i && (count_q != CntW'(DEPTH));
  assign do_rd = rd_en_i && (count_q != '0);

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (!do_wr && do_rd) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];
  assign full_o    = (count_q == CntW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign count_o   = count_q;

endmodule

// File: src/cses_front.sv
// ----------------------------------------------------------------------------
// cses_front: frame classification and signal extraction
// Matches the identifiers, pulls the signal out of the payload in Intel or
// Motorola order and works out its sign extension.
// ----------------------------------------------------------------------------
module cses_front import cses_pkg::*; #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic              push_i,
  input  logic              mid_full_i,
  input  logic [StdIdW-1:0] std_id_i,
  input  logic [IdW-1:0]    ext_id_i,
  input  logic [WordW-1:0]  payload_i,
  input  cses_cfg_t         cfg_i,
  output logic              mid_wr_o,
  output cses_mid_t         mid_item_o
);

  localparam int PayloadBits = PAYLOAD_BYTES * 8;
  localparam logic [WordW-1:0] PayloadMask =
    (PayloadBits >= WordW) ? '1 : ((WordW'(1) << PayloadBits) - WordW'(1));

  logic [LenW-1:0]   len;
  logic [WordW-1:0]  pm, len_mask, intel, mrev, mwin, mflip, moto, raw0, top_sh;
  logic [StartW-1:0] m_start;
  logic              matched, sign_ext;

  // identifier match
  assign matched = ({{(IdW-StdIdW){1'b0}}, std_id_i} == cfg_i.match_id) ||
                   (ext_id_i == cfg_i.match_id);

  // length clamp and mask
  assign len      = (cfg_i.bit_length > LenW'(WordW)) ? LenW'(WordW) : cfg_i.bit_length;
  assign len_mask = ~({WordW{1'b1}} << len);
  assign pm       = payload_i & PayloadMask;

  // intel: plain shift down
  assign intel = (pm >> cfg_i.first_bit) & len_mask;

  // motorola: flip bits within each byte so the walk becomes linear
  always_comb begin
    for (int b = 0; b < WordW / 8; b++) begin
      for (int j = 0; j < 8; j++) begin
        mrev[b*8 + j] = pm[b*8 + 7 - j];
      end
    end
  end

  assign m_start = {cfg_i.first_bit[StartW-1:3], ~cfg_i.first_bit[2:0]};
  assign mwin    = mrev >> m_start;

  always_comb begin
    for (int i = 0; i < WordW; i++) begin
      mflip[i] = mwin[WordW-1-i];
    end
  end

  // first walked bit ends up as the msb of the signal
  assign moto = mflip >> (LenW'(WordW) - len);

  assign raw0 = (cfg_i.byte_order == ORDER_INTEL) ? intel : moto;

  // sign extension from the signal's top bit
  assign top_sh   = raw0 >> (len - LenW'(1));
  assign sign_ext = cfg_i.is_signed && (len != '0) && (len < LenW'(WordW)) && top_sh[0];

  always_comb begin
    mid_item_o.matched  = matched;
    mid_item_o.sign_ext = cfg_i.is_signed;
    mid_item_o.raw      = '0;
    if (matched) begin
      mid_item_o.raw = sign_ext ? (raw0 | ~len_mask) : raw0;
    end
  end

  assign mid_wr_o = push_i && !mid_full_i;

endmodule

// File: src/cses_back.sv
// ----------------------------------------------------------------------------
// cses_back: scaling pipeline
// Multiply by the Q16.16 scale in two partial products, add the offset,
// then saturate to Q48.16. Issues only when the result queue has room.
// ----------------------------------------------------------------------------
module cses_back import cses_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cses_back_stat_t stat_i,
  input  cses_mid_t       mid_item_i,
  input  cses_cfg_t       cfg_i,
  output logic            mid_rd_o,
  output logic            out_wr_o,
  output cses_res_t       out_item_o
);

  localparam int ProdW = 65;

  logic                    v1_q, v2_q, v3_q;
  logic                    m1_q, m2_q, m3_q;
  logic [WordW-1:0]        r1_q, r2_q, r3_q;
  logic signed [ProdW-1:0] plo_q, phi_q, phi2_q;
  logic signed [ProdW-1:0] plo_d, phi_d;
  logic signed [32:0]      op_lo, op_hi;
  logic signed [ScaleW-1:0] scale_s;
  logic [SumW-1:0]         part_d, part_q, sum_d, sum_q;
  logic [OutCntW:0]        used;
  logic                    fits;

  // credit check: queue fill plus everything in flight
  assign used     = {1'b0, stat_i.out_count} + (OutCntW+1)'(v1_q) +
                    (OutCntW+1)'(v2_q) + (OutCntW+1)'(v3_q);
  assign mid_rd_o = !stat_i.mid_empty && (used < (OutCntW+1)'(OutDepth));

  // stage 1: two partial products
  assign op_lo   = $signed({1'b0, mid_item_i.raw[31:0]});
  assign op_hi   = $signed({mid_item_i.sign_ext & mid_item_i.raw[WordW-1],
                            mid_item_i.raw[WordW-1:32]});
  assign scale_s = $signed(cfg_i.scale);
  assign plo_d   = op_lo * scale_s;
  assign phi_d   = op_hi * scale_s;

  // stage 2: low product plus offset
  assign part_d = {{(SumW-ProdW){plo_q[ProdW-1]}}, plo_q} +
                  {{(SumW-OffsetW){cfg_i.offset[OffsetW-1]}}, cfg_i.offset};

  // stage 3: add the high product
  assign sum_d = {phi2_q[ProdW-1], phi2_q, 32'd0} + part_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= mid_rd_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q   <= mid_item_i.matched;
    r1_q   <= mid_item_i.raw;
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    m2_q   <= m1_q;
    r2_q   <= r1_q;
    part_q <= part_d;
    phi2_q <= phi_q;
    m3_q   <= m2_q;
    r3_q   <= r2_q;
    sum_q  <= sum_d;
  end

  // saturation to signed 64 bits
  assign fits = (&sum_q[SumW-1:WordW-1]) || !(|sum_q[SumW-1:WordW-1]);

  always_comb begin
    out_item_o.matched = m3_q;
    out_item_o.raw     = r3_q;
    out_item_o.phys    = '0;
    out_item_o.sat     = 1'b0;
    if (m3_q) begin
      if (fits) begin
        out_item_o.phys = sum_q[WordW-1:0];
      end else begin
        out_item_o.phys = sum_q[SumW-1] ? {1'b1, {(WordW-1){1'b0}}}
                                        : {1'b0, {(WordW-1){1'b1}}};
        out_item_o.sat  = 1'b1;
      end
    end
  end

  assign out_wr_o = v3_q;

endmodule

// File: src/can_signal_extract_scale_unit.sv
// ----------------------------------------------------------------------------
// can_signal_extract_scale_unit: CAN signal decode and scaling
// Extracts one configured signal from matching frames and scales it to a
// saturated signed Q48.16 physical value.
// ----------------------------------------------------------------------------
//   channel   direction  handshake             payload
//   frame     in         push / full           std_id, ext_id, payload
//   result    out        pop / empty           matched, raw_value,
//                                              physical_value, saturated
//   config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// one frame per cycle sustained while results are popped; on its way to the
// result side a frame passes the mid queue write, three back-end stages
// around the two partial multipliers and the wide adds, and the result queue
// the back end issues only when the result queue can hold every item in
// flight, so a stalled pop fills the queues and then raises full
// reset clears the config registers to their defaults and empties both queues
// ----------------------------------------------------------------------------
module can_signal_extract_scale_unit import cses_pkg::*; #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [StdIdW-1:0]   std_id_i,
  input  logic [IdW-1:0]      ext_id_i,
  input  logic [WordW-1:0]    payload_i,
  output logic                empty,
  input  logic                pop,
  output logic                matched_o,
  output logic [WordW-1:0]    raw_value_o,
  output logic signed [WordW-1:0] physical_value_o,
  output logic                saturated_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cses_cfg_t       cfg_q, cfg_d;
  cses_mid_t       mid_wr_item, mid_rd_item;
  cses_res_t       out_wr_item, out_rd_item;
  cses_back_stat_t back_stat;
  logic            mid_wr, mid_rd, mid_full, mid_empty;
  logic            out_wr, out_full;
  logic [$clog2(MidDepth+1)-1:0] mid_count;
  logic [OutCntW-1:0] out_count;

  // config register writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cses_reg_e'(cfg_index_i))
        REG_MATCH_ID:   cfg_d.match_id   = cfg_data_i[IdW-1:0];
        REG_FIRST_BIT:  cfg_d.first_bit  = cfg_data_i[StartW-1:0];
        REG_BIT_LENGTH: cfg_d.bit_length = cfg_data_i[LenW-1:0];
        REG_BYTE_ORDER: cfg_d.byte_order = cfg_data_i[0];
        REG_IS_SIGNED:  cfg_d.is_signed  = cfg_data_i[0];
        REG_SCALE:      cfg_d.scale      = cfg_data_i[ScaleW-1:0];
        REG_OFFSET:     cfg_d.offset     = cfg_data_i[OffsetW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_id   <= RstMatchId;
      cfg_q.first_bit  <= RstFirstBit;
      cfg_q.bit_length <= RstBitLength;
      cfg_q.byte_order <= RstByteOrder;
      cfg_q.is_signed  <= RstIsSigned;
      cfg_q.scale      <= RstScale;
      cfg_q.offset     <= RstOffset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: match and extract
  cses_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .push_i     (push),
    .mid_full_i (mid_full),
    .std_id_i   (std_id_i),
    .ext_id_i   (ext_id_i),
    .payload_i  (payload_i),
    .cfg_i      (cfg_q),
    .mid_wr_o   (mid_wr),
    .mid_item_o (mid_wr_item)
  );

  // queue between front and back
  cses_fifo #(
    .WIDTH ($bits(cses_mid_t)),
    .DEPTH (MidDepth)
  ) u_mid_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mid_wr),
    .wr_data_i (mid_wr_item),
    .rd_en_i   (mid_rd),
    .rd_data_o (mid_rd_item),
    .full_o    (mid_full),
    .empty_o   (mid_empty),
    .count_o   (mid_count)
  );

  assign full = mid_full && (mid_count == ($clog2(MidDepth+1))'(MidDepth));

  // back: scale, offset, saturate
  assign back_stat.mid_empty = mid_empty;
  assign back_stat.out_count = out_count;

  cses_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stat_i     (back_stat),
    .mid_item_i (mid_rd_item),
    .cfg_i      (cfg_q),
    .mid_rd_o   (mid_rd),
    .out_wr_o   (out_wr),
    .out_item_o (out_wr_item)
  );

  // result queue
  cses_fifo #(
    .WIDTH ($bits(cses_res_t)),
    .DEPTH (OutDepth)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (out_wr && !out_full),
    .wr_data_i (out_wr_item),
    .rd_en_i   (pop),
    .rd_data_o (out_rd_item),
    .full_o    (out_full),
    .empty_o   (empty),
    .count_o   (out_count)
  );

  assign matched_o        = out_rd_item.matched;
  assign raw_value_o      = out_rd_item.raw;
  assign physical_value_o = out_rd_item.phys;
  assign saturated_o      = out_rd_item.sat;

endmodule

// File: src/cses_checker.sv
// ----------------------------------------------------------------------------
// cses_checker: port-level checks of the CAN signal extract/scale unit
// Result consistency and output hold under back-pressure.
// ----------------------------------------------------------------------------
module cses_checker import cses_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input logic                matched_o,
  input logic [WordW-1:0]    raw_value_o,
  input logic [WordW-1:0]    physical_value_o,
  input logic                saturated_o
);

  localparam logic [WordW-1:0] PosSat = {1'b0, {(WordW-1){1'b1}}};
  localparam logic [WordW-1:0] NegSat = {1'b1, {(WordW-1){1'b0}}};

  // unmatched frames report all zero
  a_unmatched_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !matched_o) |-> (raw_value_o == '0 && physical_value_o == '0 &&
                                !saturated_o))
    else $error("unmatched result carries non-zero fields");

  // a clipped value sits at one of the two limits
  a_sat_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && saturated_o) |-> (physical_value_o == PosSat ||
                                 physical_value_o == NegSat))
    else $error("saturated result not at a limit");

  // saturation only on matched frames
  a_sat_matched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && saturated_o) |-> matched_o)
    else $error("saturation flagged on unmatched frame");

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(raw_value_o) &&
                          $stable(physical_value_o) && $stable(saturated_o)))
    else $error("waiting result changed before transfer");

endmodule

bind can_signal_extract_scale_unit cses_checker u_cses_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .matched_o        (matched_o),
  .raw_value_o      (raw_value_o),
  .physical_value_o (physical_value_o),
  .saturated_o      (saturated_o)
);

// File: tb/sv/cses_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cses_decode_checker: result checker for the CAN signal extract/scale unit
// Follows every register write, decodes each accepted frame on its own and
// compares each popped result, field by field, with the oldest decode.
// ----------------------------------------------------------------------------
module cses_decode_checker import cses_pkg::*; #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic                    full_i,
  input  logic [StdIdW-1:0]       std_id_i,
  input  logic [IdW-1:0]          ext_id_i,
  input  logic [WordW-1:0]        payload_i,
  input  logic                    empty_i,
  input  logic                    pop_i,
  input  logic                    matched_i,
  input  logic [WordW-1:0]        raw_value_i,
  input  logic signed [WordW-1:0] physical_value_i,
  input  logic                    saturated_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  // wide enough for a 65-bit raw times a 32-bit scale plus the offset
  localparam int AccW = WordW + ScaleW + 4;

  cses_cfg_t sig_cfg;
  cses_res_t decoded_q[$];

  // decode one frame under the given register set
  function automatic cses_res_t decode_frame(input cses_cfg_t c,
                                             input logic [StdIdW-1:0] sid,
                                             input logic [IdW-1:0] eid,
                                             input logic [WordW-1:0] pl);
    cses_res_t                res;
    int unsigned              len;
    int unsigned              pos;
    int unsigned              k;
    logic                     bit_v;
    logic [WordW-1:0]         raw;
    logic signed [WordW:0]    raw_s;
    logic signed [ScaleW-1:0] sc;
    logic signed [OffsetW-1:0] off;
    logic signed [AccW-1:0]   acc;
    res = '0;
    if (sid != c.match_id && eid != c.match_id) return res;

    // lengths above a word act as a full word
    len = (c.bit_length > WordW) ? WordW : 32'(c.bit_length);
    raw = '0;
    pos = 32'(c.first_bit);
    for (k = 0; k < len; k++) begin
      if (c.byte_order == ORDER_INTEL) pos = 32'(c.first_bit) + k;
      // positions past the payload read as zero
      bit_v = (pos < PAYLOAD_BYTES * 8) ? pl[pos] : 1'b0;
      if (c.byte_order == ORDER_INTEL) begin
        raw[k] = bit_v;
      end else begin
        // motorola walk: msb first, jump to the next byte's top bit
        raw = {raw[WordW-2:0], bit_v};
        pos = (pos % 8 == 0) ? pos + 15 : pos - 1;
      end
    end
    if (c.is_signed && len > 0 && len < WordW && raw[len-1])
      raw = raw | ~((64'd1 << len) - 64'd1);

    // exact raw * scale + offset, then clip to 64 signed bits
    raw_s = c.is_signed ? {raw[WordW-1], raw} : {1'b0, raw};
    sc    = c.scale;
    off   = c.offset;
    acc   = raw_s * sc + off;
    res.matched = 1'b1;
    res.raw     = raw;
    if (acc[AccW-1:WordW-1] == {(AccW-WordW+1){acc[WordW-1]}}) begin
      res.phys = acc[WordW-1:0];
      res.sat  = 1'b0;
    end else begin
      res.phys = acc[AccW-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      res.sat  = 1'b1;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [WordW-1:0] exp_v,
                             input logic [WordW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cses_res_t exp_r;
    if (!rst_ni) begin
      sig_cfg = {RstMatchId, RstFirstBit, RstBitLength, RstByteOrder, RstIsSigned,
                 RstScale, RstOffset};
      decoded_q.delete();
      pending_o = 0;
    end else begin
      // result transfer against the oldest decode
      if (pop_i && !empty_i) begin
        if (decoded_q.size() == 0) begin
          $error("result popped with no frame waiting for it");
          fail_count_o++;
        end else begin
          exp_r = decoded_q.pop_front();
          check_field("matched", WordW'(exp_r.matched), WordW'(matched_i));
          check_field("raw_value", exp_r.raw, raw_value_i);
          check_field("physical_value", exp_r.phys, physical_value_i);
          check_field("saturated", WordW'(exp_r.sat), WordW'(saturated_i));
        end
      end

      // frame transfer, decoded with the registers in force now
      if (push_i && !full_i)
        decoded_q.push_back(decode_frame(sig_cfg, std_id_i, ext_id_i, payload_i));

      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cses_reg_e'(cfg_index_i))
          REG_MATCH_ID:   sig_cfg.match_id   = cfg_data_i[IdW-1:0];
          REG_FIRST_BIT:  sig_cfg.first_bit  = cfg_data_i[StartW-1:0];
          REG_BIT_LENGTH: sig_cfg.bit_length = cfg_data_i[LenW-1:0];
          REG_BYTE_ORDER: sig_cfg.byte_order = cfg_data_i[0];
          REG_IS_SIGNED:  sig_cfg.is_signed  = cfg_data_i[0];
          REG_SCALE:      sig_cfg.scale      = cfg_data_i[ScaleW-1:0];
          REG_OFFSET:     sig_cfg.offset     = cfg_data_i[OffsetW-1:0];
          default: ;
        endcase
      end
      pending_o = decoded_q.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: frame and register stimulus for the CAN signal extract/scale unit
// Directed frames over the corner settings, then randomised register sets
// with mostly matching frames, under changing push and pop back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import cses_pkg::*;

  localparam int FrameBytes   = 8;
  localparam int RandPhases   = 24;
  localparam int FramesPerSet = 52;
  localparam int SettleCycles = 10;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    push = 1'b0;
  logic                    full;
  logic [StdIdW-1:0]       std_id = '0;
  logic [IdW-1:0]          ext_id = '0;
  logic [WordW-1:0]        payload = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic                    matched;
  logic [WordW-1:0]        raw_value;
  logic signed [WordW-1:0] physical_value;
  logic                    saturated;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  cses_reg_e               cfg_index = REG_MATCH_ID;
  logic [CfgDataW-1:0]     cfg_data = '0;
  int                      err_count;
  int                      outstanding;
  int                      send_idle_pct = 0;
  int                      pop_stall_pct = 0;

  can_signal_extract_scale_unit #(.PAYLOAD_BYTES(FrameBytes)) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push             (push),
    .full             (full),
    .std_id_i         (std_id),
    .ext_id_i         (ext_id),
    .payload_i        (payload),
    .empty            (empty),
    .pop              (pop),
    .matched_o        (matched),
    .raw_value_o      (raw_value),
    .physical_value_o (physical_value),
    .saturated_o      (saturated),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  cses_decode_checker #(.PAYLOAD_BYTES(FrameBytes)) checker_inst (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push_i           (push),
    .full_i           (full),
    .std_id_i         (std_id),
    .ext_id_i         (ext_id),
    .payload_i        (payload),
    .empty_i          (empty),
    .pop_i            (pop),
    .matched_i        (matched),
    .raw_value_i      (raw_value),
    .physical_value_i (physical_value),
    .saturated_i      (saturated),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (err_count),
    .pending_o        (outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic cses_cfg_t mk_cfg(input logic [IdW-1:0] id,
                                       input logic [StartW-1:0] start,
                                       input logic [LenW-1:0] len,
                                       input logic order, input logic sgn,
                                       input logic [ScaleW-1:0] sc,
                                       input logic [OffsetW-1:0] off);
    return {id, start, len, order, sgn, sc, off};
  endfunction

  // random register set, extremes picked often
  function automatic cses_cfg_t rand_cfg();
    cses_cfg_t c;
    case ($urandom_range(3))
      0:       c.match_id = IdW'($urandom_range(2047));
      1:       c.match_id = $urandom_range(1) ? 29'h1FFF_FFFF : 29'd0;
      default: c.match_id = IdW'($urandom_range(29'h1FFF_FFFF));
    endcase
    if ($urandom_range(3) == 0) c.first_bit = $urandom_range(1) ? 6'd63 : 6'd0;
    else c.first_bit = StartW'($urandom_range(63));
    case ($urandom_range(19))
      0:       c.bit_length = 7'd0;
      1:       c.bit_length = 7'd64;
      2:       c.bit_length = LenW'($urandom_range(127, 65));
      3:       c.bit_length = 7'd1;
      default: c.bit_length = LenW'($urandom_range(64, 1));
    endcase
    c.byte_order = $urandom_range(1) ? ORDER_INTEL : ORDER_MOTOROLA;
    c.is_signed  = 1'($urandom_range(1));
    case ($urandom_range(7))
      0:       c.scale = 32'h8000_0000;
      1:       c.scale = 32'h7FFF_FFFF;
      2:       c.scale = 32'd65536;
      3:       c.scale = 32'd0;
      default: c.scale = $urandom;
    endcase
    case ($urandom_range(5))
      0:       c.offset = 48'h8000_0000_0000;
      1:       c.offset = 48'h7FFF_FFFF_FFFF;
      2:       c.offset = 48'd0;
      default: c.offset = OffsetW'({$urandom, $urandom});
    endcase
    return c;
  endfunction

  task automatic set_idling(input int mode);
    send_idle_pct = (mode == 1) ? 67 : (mode == 3) ? 11 : 0;
    pop_stall_pct = (mode == 2) ? 67 : (mode == 3) ? 11 : 0;
  endtask

  // one register transfer; valid stays high for the next one
  task automatic put_reg(input cses_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_settings(input cses_cfg_t c);
    put_reg(REG_MATCH_ID, CfgDataW'(c.match_id));
    put_reg(REG_FIRST_BIT, CfgDataW'(c.first_bit));
    put_reg(REG_BIT_LENGTH, CfgDataW'(c.bit_length));
    put_reg(REG_BYTE_ORDER, CfgDataW'(c.byte_order));
    put_reg(REG_IS_SIGNED, CfgDataW'(c.is_signed));
    put_reg(REG_SCALE, CfgDataW'(c.scale));
    put_reg(REG_OFFSET, c.offset);
    cfg_valid <= 1'b0;
  endtask

  // frame transfer after a random gap
  task automatic send_frame(input logic [StdIdW-1:0] sid, input logic [IdW-1:0] eid,
                            input logic [WordW-1:0] pl);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    std_id  <= sid;
    ext_id  <= eid;
    payload <= pl;
    do @(posedge clk); while (full);
  endtask

  // stop pushing and let every predicted result come out
  task automatic wait_idle();
    push <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    cses_cfg_t         cfg;
    logic [StdIdW-1:0] sid;
    logic [IdW-1:0]    eid;
    logic [WordW-1:0]  pl;
    int unsigned       pick;
    int                ph;
    int                n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: intel, start 0, 8 bits, unity scale, match on id 0
    set_idling(0);
    send_frame(11'd0, 29'h1FFF_FFFF, '1);
    send_frame(11'h7FF, 29'd0, '0);
    send_frame(11'h7FF, 29'h1FFF_FFFF, 64'h0123_4567_89AB_CDEF);

    // motorola from the top bit, oversized length walks off the payload
    wait_idle();
    write_settings(mk_cfg(29'h1FFF_FFFF, 6'd63, 7'd127, ORDER_MOTOROLA, 1'b1,
                          32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF));
    set_idling(3);
    send_frame(11'h7FF, 29'h1FFF_FFFF, '1);
    send_frame(11'h7FF, 29'h1FFF_FFFF, '0);
    send_frame(11'h7FF, 29'h0FFF_FFFF, '1);

    // full unsigned word, largest raw into largest scale
    wait_idle();
    write_settings(mk_cfg(29'd2047, 6'd0, 7'd64, ORDER_INTEL, 1'b0,
                          32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF));
    send_frame(11'h7FF, 29'd0, '1);
    send_frame(11'h7FF, 29'd2047, 64'h8000_0000_0000_0000);
    send_frame(11'd0, 29'd2047, '0);

    // intel past the payload end, most negative scale and offset
    wait_idle();
    write_settings(mk_cfg(29'd5, 6'd60, 7'd8, ORDER_INTEL, 1'b1,
                          32'h8000_0000, 48'h8000_0000_0000));
    set_idling(1);
    send_frame(11'd5, 29'd5, '1);
    send_frame(11'd5, 29'd6, '0);
    send_frame(11'd4, 29'd5, 64'hF000_0000_0000_0000);

    // zero length with sign extension enabled
    wait_idle();
    write_settings(mk_cfg(29'd5, 6'd7, 7'd0, ORDER_MOTOROLA, 1'b1, 32'd0, 48'd0));
    set_idling(2);
    send_frame(11'd5, 29'd0, '1);
    send_frame(11'd0, 29'd5, '1);

    // one signed bit into a scale of all ones (minus one lsb)
    wait_idle();
    write_settings(mk_cfg(29'd5, 6'd0, 7'd1, ORDER_MOTOROLA, 1'b1, 32'hFFFF_FFFF, 48'd0));
    send_frame(11'd5, 29'd0, 64'd1);
    send_frame(11'd5, 29'd0, 64'hFFFF_FFFF_FFFF_FFFE);

    // whole word in motorola order, most negative raw times most negative scale
    wait_idle();
    write_settings(mk_cfg(29'd5, 6'd7, 7'd64, ORDER_MOTOROLA, 1'b1,
                          32'h8000_0000, 48'h7FFF_FFFF_FFFF));
    set_idling(0);
    send_frame(11'd5, 29'd0, 64'h80);
    send_frame(11'd5, 29'd0, '1);
    send_frame(11'd5, 29'd0, 64'h0123_4567_89AB_CDEF);

    // random register sets, mostly matching frames
    for (ph = 0; ph < RandPhases; ph++) begin
      wait_idle();
      cfg = rand_cfg();
      write_settings(cfg);
      set_idling(ph % 4);
      for (n = 0; n < FramesPerSet; n++) begin
        pick = $urandom_range(9);
        sid  = StdIdW'($urandom_range(2047));
        eid  = IdW'($urandom_range(29'h1FFF_FFFF));
        if (pick < 4) begin
          eid = cfg.match_id;
        end else if (pick < 7 && cfg.match_id < 2048) begin
          sid = cfg.match_id[StdIdW-1:0];
          if (pick == 6) eid = cfg.match_id;
        end
        case ($urandom_range(15))
          0:       pl = '0;
          1:       pl = '1;
          2:       pl = 64'd1 << $urandom_range(63);
          default: pl = {$urandom, $urandom};
        endcase
        send_frame(sid, eid, pl);
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
